@@ hdl/sjb_pkg.sv @@
// Shared types and constants of the serial jitter buffer.
package sjb_pkg;

    localparam int FIFO_DEPTH_DEF = 512;
    localparam int CNT_W_DEF      = 32;

    localparam int RESUME_W = 10;
    localparam int SKIP_W   = 8;
    localparam int PULSE_W  = 16;
    localparam int DELAY_W  = 19;
    localparam int DATA_W   = 8;
    localparam int MODE_W   = 2;
    localparam int PADDR_W  = 4;

    localparam logic [RESUME_W-1:0] RESUME_RST   = 10'd8;
    localparam logic [SKIP_W-1:0]   SKIP_LIM_RST = 8'd8;
    localparam logic [PULSE_W-1:0]  MIN_PULSE_RST = 16'd40;
    localparam logic [PULSE_W-1:0]  FALLBACK_RST  = 16'd12000;
    localparam logic [SKIP_W-1:0]   SKIP_MAX      = 8'd255;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RESUME   = 2'd0;
    localparam logic [1:0] REG_SKIP_LIM = 2'd1;
    localparam logic [1:0] REG_MIN_PW   = 2'd2;
    localparam logic [1:0] REG_FALLBACK = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_TICK    = 2'd1,
        OP_SESSION = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  data;
        logic [PULSE_W-1:0] pulse;
    } t_cmd;

    typedef struct packed {
        logic               byte_valid;
        logic               delay_valid;
        logic [DELAY_W-1:0] delay;
        logic               dropped;
        logic               buffering;
    } t_flags;

endpackage

@@ hdl/sjb_front.sv @@
// Front end: accepts commands, resolves the pulse width and queues them for the back end.
module sjb_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sjb_pkg::MODE_W-1:0]   i_mode,
    input  logic [sjb_pkg::DATA_W-1:0]   i_data_byte,
    input  logic [sjb_pkg::PULSE_W-1:0]  i_pulse_width,
    input  logic [sjb_pkg::PULSE_W-1:0]  i_min_pulse,
    input  logic [sjb_pkg::PULSE_W-1:0]  i_fallback_pulse,
    output logic                         o_busy,
    output logic                         o_cmd_valid,
    output sjb_pkg::t_cmd                o_cmd
);

    sjb_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    sjb_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd.op    = sjb_pkg::t_op'(i_mode);
        w_cmd.data  = i_data_byte;
        w_cmd.pulse = (i_pulse_width < i_min_pulse) ? i_fallback_pulse : i_pulse_width;
    end

    assign o_busy      = (r_cnt == 2'd2);
    assign w_push      = i_start & ~o_busy;
    // The back end takes one word every cycle, so the head leaves as soon as it is there.
    assign w_pop       = (r_cnt != 2'd0);
    assign o_cmd_valid = w_pop;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ hdl/sjb_back.sv @@
// Back end: byte store, buffering control, session counters and the result register.
module sjb_back #(
    parameter int FIFO_DEPTH = sjb_pkg::FIFO_DEPTH_DEF,
    parameter int CNT_W      = sjb_pkg::CNT_W_DEF,
    parameter int AW         = $clog2(FIFO_DEPTH),
    parameter int FW         = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  sjb_pkg::t_cmd                 i_cmd,
    input  logic [sjb_pkg::RESUME_W-1:0]  i_resume_level,
    input  logic [sjb_pkg::SKIP_W-1:0]    i_skip_limit,
    output logic                          o_valid,
    output sjb_pkg::t_flags               o_flags,
    output logic [sjb_pkg::DATA_W-1:0]    o_byte,
    output logic [FW-1:0]                 o_fill,
    output logic [CNT_W-1:0]              o_lost,
    output logic [CNT_W-1:0]              o_processed
);

    localparam int RW = (FW > sjb_pkg::RESUME_W) ? FW : sjb_pkg::RESUME_W;
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [FW-1:0] FULL = FW'(FIFO_DEPTH);

    logic [sjb_pkg::DATA_W-1:0] r_mem [FIFO_DEPTH];
    logic [sjb_pkg::DATA_W-1:0] r_rd_data;

    logic [AW-1:0]               r_rp, n_rp;
    logic [AW-1:0]               r_wp, n_wp;
    logic [FW-1:0]               r_fill, n_fill;
    logic                        r_buf, n_buf;
    logic [sjb_pkg::SKIP_W-1:0]  r_skip, n_skip;
    logic [CNT_W-1:0]            r_lost, n_lost;
    logic [CNT_W-1:0]            r_proc, n_proc;
    logic                        r_valid;
    sjb_pkg::t_flags             r_flags, n_flags;
    logic                        w_wr;
    logic                        w_rd;

    always_comb begin
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_fill  = r_fill;
        n_buf   = r_buf;
        n_skip  = r_skip;
        n_lost  = r_lost;
        n_proc  = r_proc;
        w_wr    = 1'b0;
        w_rd    = 1'b0;
        n_flags = '0;
        if (i_cmd_valid) begin
            case (i_cmd.op)
                sjb_pkg::OP_PUSH: begin
                    if (r_fill < FULL) begin
                        w_wr   = 1'b1;
                        n_wp   = (r_wp == LAST) ? '0 : r_wp + 1'b1;
                        n_fill = r_fill + 1'b1;
                        if (RW'(n_fill) >= RW'(i_resume_level)) begin
                            n_buf = 1'b0;
                        end
                    end else begin
                        n_lost          = r_lost + 1'b1;
                        n_flags.dropped = 1'b1;
                    end
                end
                sjb_pkg::OP_TICK: begin
                    if (r_fill == '0) begin
                        n_buf = 1'b1;
                    end else if (r_buf) begin
                        // The skip count saturates; it still ends buffering past the limit.
                        if (r_skip < sjb_pkg::SKIP_MAX) begin
                            n_skip = r_skip + 1'b1;
                        end
                        if (n_skip > i_skip_limit) begin
                            n_buf = 1'b0;
                        end
                    end else begin
                        w_rd               = 1'b1;
                        n_flags.byte_valid = 1'b1;
                        n_rp               = (r_rp == LAST) ? '0 : r_rp + 1'b1;
                        n_fill             = r_fill - 1'b1;
                        n_proc             = r_proc + 1'b1;
                        n_skip             = '0;
                    end
                    n_flags.delay_valid = 1'b1;
                    n_flags.delay       = {i_cmd.pulse, 3'b000};
                end
                sjb_pkg::OP_SESSION: begin
                    n_skip = '0;
                    n_lost = '0;
                    n_proc = '0;
                end
                default: begin
                end
            endcase
        end
        n_flags.buffering = n_buf;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        if (w_rd) begin
            r_rd_data <= r_mem[r_rp];
        end
        r_flags <= n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_buf   <= 1'b0;
            r_skip  <= '0;
            r_lost  <= '0;
            r_proc  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_buf   <= n_buf;
            r_skip  <= n_skip;
            r_lost  <= n_lost;
            r_proc  <= n_proc;
            r_valid <= i_cmd_valid;
        end
    end

    assign o_valid     = r_valid;
    assign o_flags     = r_flags;
    assign o_byte      = r_flags.byte_valid ? r_rd_data : '0;
    assign o_fill      = r_fill;
    assign o_lost      = r_lost;
    assign o_processed = r_proc;

endmodule

@@ hdl/serial_jitter_buffer.sv @@
// Top level of the serial jitter buffer: configuration registers, front and back ends.
//
// Commands enter on start with mode, data_byte and pulse_width; a word is taken at a
// rising edge where start is high and busy is low. Mode 0 pushes a byte, mode 1 is a
// delivery tick, mode 2 starts a session, mode 3 only reports status.
// Every command produces exactly one result, shown for one cycle with o_valid high.
// A command taken at a rising edge is first registered in the queue; the back end then
// executes it and registers its result, which is shown on the outputs. One command per
// cycle is sustained; a two-word queue separates the command front end from the back
// end that owns the byte store, whose single write/read port handles the one push or
// pop of each command.
// busy only rises if the queue fills, which the back end, draining a word each cycle,
// never lets happen.
// The receiver cannot hold results off; each one is valid for its single cycle only.
// Reset (synchronous, active low) empties the store, clears buffering and all
// counters, and loads the register defaults. The store contents are not cleared.
// Registers sit at byte addresses 0, 4, 8 and 12 on the APB-style port and may only
// be written while no command is in flight.
module serial_jitter_buffer #(
    parameter int FIFO_DEPTH = sjb_pkg::FIFO_DEPTH_DEF,
    parameter int CNT_W      = sjb_pkg::CNT_W_DEF,
    parameter int FW         = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sjb_pkg::MODE_W-1:0]    i_mode,
    input  logic [sjb_pkg::DATA_W-1:0]    i_data_byte,
    input  logic [sjb_pkg::PULSE_W-1:0]   i_pulse_width,
    output logic                          o_valid,
    output logic                          o_byte_valid,
    output logic [sjb_pkg::DATA_W-1:0]    o_byte_out,
    output logic                          o_delay_valid,
    output logic [sjb_pkg::DELAY_W-1:0]   o_next_delay,
    output logic                          o_dropped,
    output logic                          o_is_buffering,
    output logic [FW-1:0]                 o_fill_level,
    output logic [CNT_W-1:0]              o_lost_total,
    output logic [CNT_W-1:0]              o_processed_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sjb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [sjb_pkg::RESUME_W-1:0] r_resume;
    logic [sjb_pkg::SKIP_W-1:0]   r_skip_lim;
    logic [sjb_pkg::PULSE_W-1:0]  r_min_pw;
    logic [sjb_pkg::PULSE_W-1:0]  r_fallback;
    logic                         w_cfg_wr;
    logic [1:0]                   w_reg;
    logic                         w_cmd_valid;
    sjb_pkg::t_cmd                w_cmd;
    sjb_pkg::t_flags              w_flags;

    assign pready   = 1'b1;
    assign w_reg    = paddr[3:2];
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resume   <= sjb_pkg::RESUME_RST;
            r_skip_lim <= sjb_pkg::SKIP_LIM_RST;
            r_min_pw   <= sjb_pkg::MIN_PULSE_RST;
            r_fallback <= sjb_pkg::FALLBACK_RST;
        end else if (w_cfg_wr) begin
            case (w_reg)
                sjb_pkg::REG_RESUME:   r_resume   <= pwdata[sjb_pkg::RESUME_W-1:0];
                sjb_pkg::REG_SKIP_LIM: r_skip_lim <= pwdata[sjb_pkg::SKIP_W-1:0];
                sjb_pkg::REG_MIN_PW:   r_min_pw   <= pwdata[sjb_pkg::PULSE_W-1:0];
                sjb_pkg::REG_FALLBACK: r_fallback <= pwdata[sjb_pkg::PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            sjb_pkg::REG_RESUME:   prdata = 32'(r_resume);
            sjb_pkg::REG_SKIP_LIM: prdata = 32'(r_skip_lim);
            sjb_pkg::REG_MIN_PW:   prdata = 32'(r_min_pw);
            sjb_pkg::REG_FALLBACK: prdata = 32'(r_fallback);
            default:               prdata = '0;
        endcase
    end

    sjb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_pulse_width    (i_pulse_width),
        .i_min_pulse      (r_min_pw),
        .i_fallback_pulse (r_fallback),
        .o_busy           (busy),
        .o_cmd_valid      (w_cmd_valid),
        .o_cmd            (w_cmd)
    );

    sjb_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CNT_W      (CNT_W),
        .FW         (FW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .i_resume_level (r_resume),
        .i_skip_limit   (r_skip_lim),
        .o_valid        (o_valid),
        .o_flags        (w_flags),
        .o_byte         (o_byte_out),
        .o_fill         (o_fill_level),
        .o_lost         (o_lost_total),
        .o_processed    (o_processed_total)
    );

    assign o_byte_valid   = w_flags.byte_valid;
    assign o_delay_valid  = w_flags.delay_valid;
    assign o_next_delay   = w_flags.delay;
    assign o_dropped      = w_flags.dropped;
    assign o_is_buffering = w_flags.buffering;

`ifndef SYNTH
    // Each accepted word yields its result with o_valid high.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing two cycles after an accepted word");

    // A delivered byte and a dropped byte cannot come from the same word.
    a_byte_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_byte_valid && o_dropped))
        else $error("byte delivered and dropped together");

    // A delivery leaves the buffering flag clear.
    a_deliver_not_buffering: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> !o_is_buffering)
        else $error("byte delivered while buffering");

    // The fill level never exceeds the store depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fill_level <= FW'(FIFO_DEPTH))
        else $error("fill level above store depth");
`endif

endmodule
